// ===== rtl/polyr_pkg.sv =====
// Shared types and constants for the Horner polynomial evaluator.
package polyr_pkg;

  localparam int unsigned ACC_W     = 48;
  localparam int unsigned X_W       = 32;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned DEG_W     = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned MUL_A_W   = ACC_W / 2;
  localparam int unsigned PP_W      = MUL_A_W + X_W;
  localparam int unsigned PROD_W    = ACC_W + X_W;
  localparam int unsigned SUM_W     = ACC_W + 2;
  localparam int unsigned RND_W     = ACC_W + 1;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACCUM,
    ST_FMAG,
    ST_ROUND
  } state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul_lo;
    logic mul_hi;
    logic accum;
    logic fmag;
    logic round;
  } dp_ctrl_t;

endpackage

// ===== rtl/polynomial_eval_round_saturate.sv =====
// Top level of the Horner polynomial evaluator with rounding and saturation.
// A sample is taken when start is high while busy is low. Each coefficient
// step takes the accumulator magnitude, runs it twice through one shared
// 24x32 multiplier, then rescales and adds; magnitude and rounding states
// end the run. The rounding state registers the result word and done_o;
// busy drops as done_o rises, so a new sample may start while the result
// is shown. done_o is a one-cycle strobe; the receiver must take the word
// then. Configuration writes are always accepted and belong in idle periods.
module polynomial_eval_round_saturate #(
  parameter int unsigned MAX_DEGREE = 6,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [polyr_pkg::X_W-1:0]     sample_x_i,
  output logic                                 done_o,
  output logic signed [polyr_pkg::OUT_W-1:0]   result_value_o,
  output logic                                 clipped_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [polyr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [polyr_pkg::COEF_W-1:0]         cfg_data_i
);

  localparam int unsigned CIDX_W = $clog2(MAX_DEGREE + 1);

  logic [polyr_pkg::DEG_W-1:0]         degree;
  logic signed [polyr_pkg::COEF_W-1:0] coef;
  logic [CIDX_W-1:0]                   coef_sel;
  polyr_pkg::dp_ctrl_t                 dp_ctrl;

  assign cfg_ready_o = 1'b1;

  polyr_cfg #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_sel_i  (coef_sel),
    .degree_o    (degree),
    .coef_o      (coef)
  );

  polyr_ctrl #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .degree_i   (degree),
    .busy       (busy),
    .done_o     (done_o),
    .coef_sel_o (coef_sel),
    .ctrl_o     (dp_ctrl)
  );

  polyr_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (dp_ctrl),
    .sample_x_i     (sample_x_i),
    .coef_i         (coef),
    .result_value_o (result_value_o),
    .clipped_o      (clipped_o)
  );

endmodule

// ===== rtl/polyr_cfg.sv =====
// Configuration register file: degree and coefficients.
module polyr_cfg #(
  parameter int unsigned MAX_DEGREE = 6,
  localparam int unsigned NUM_COEFS = MAX_DEGREE + 1,
  localparam int unsigned CIDX_W    = $clog2(NUM_COEFS)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [polyr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [polyr_pkg::COEF_W-1:0]         cfg_data_i,
  input  logic [CIDX_W-1:0]                    coef_sel_i,
  output logic [polyr_pkg::DEG_W-1:0]          degree_o,
  output logic signed [polyr_pkg::COEF_W-1:0]  coef_o
);

  logic [polyr_pkg::DEG_W-1:0]  degree_q, degree_d;
  logic [polyr_pkg::COEF_W-1:0] coef_q [NUM_COEFS];
  logic [polyr_pkg::COEF_W-1:0] coef_d [NUM_COEFS];

  always_comb begin
    degree_d = degree_q;
    for (int k = 0; k < NUM_COEFS; k++) begin
      coef_d[k] = coef_q[k];
    end
    if (cfg_valid_i) begin
      if (cfg_index_i == polyr_pkg::REG_DEGREE) begin
        degree_d = cfg_data_i[polyr_pkg::DEG_W-1:0];
      end
      for (int k = 0; k < NUM_COEFS; k++) begin
        if ({1'b0, cfg_index_i} == (polyr_pkg::CFG_IDX_W+1)'(k + 1)) begin
          coef_d[k] = cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
      for (int k = 0; k < NUM_COEFS; k++) begin
        coef_q[k] <= '0;
      end
    end else begin
      degree_q <= degree_d;
      for (int k = 0; k < NUM_COEFS; k++) begin
        coef_q[k] <= coef_d[k];
      end
    end
  end

  assign degree_o = degree_q;
  assign coef_o   = $signed(coef_q[coef_sel_i]);

endmodule

// ===== rtl/polyr_mul.sv =====
// Shared multiplier: one half of the accumulator magnitude times |x|.
module polyr_mul (
  input  logic [polyr_pkg::ACC_W-1:0] amag_i,
  input  logic [polyr_pkg::X_W-1:0]   xmag_i,
  input  logic                        hi_i,
  output logic [polyr_pkg::PP_W-1:0]  pp_o
);

  logic [polyr_pkg::MUL_A_W-1:0] a_half;

  assign a_half = hi_i ? amag_i[polyr_pkg::ACC_W-1:polyr_pkg::MUL_A_W]
                       : amag_i[polyr_pkg::MUL_A_W-1:0];
  assign pp_o   = polyr_pkg::PP_W'(a_half) * polyr_pkg::PP_W'(xmag_i);

endmodule

// ===== rtl/polyr_ctrl.sv =====
// Sequencer: walks coefficients from the top down and steps the datapath.
module polyr_ctrl #(
  parameter int unsigned MAX_DEGREE = 6,
  localparam int unsigned CIDX_W    = $clog2(MAX_DEGREE + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [polyr_pkg::DEG_W-1:0] degree_i,
  output logic                        busy,
  output logic                        done_o,
  output logic [CIDX_W-1:0]           coef_sel_o,
  output polyr_pkg::dp_ctrl_t         ctrl_o
);

  polyr_pkg::state_e state_q, state_d;
  logic [CIDX_W-1:0] idx_q, idx_d;
  logic              done_q, done_d;
  logic [CIDX_W-1:0] deg_clamp;

  assign deg_clamp = (degree_i > polyr_pkg::DEG_W'(MAX_DEGREE)) ? CIDX_W'(MAX_DEGREE)
                                                                 : degree_i[CIDX_W-1:0];

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    done_d  = 1'b0;
    ctrl_o  = '0;
    case (state_q)
      polyr_pkg::ST_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          idx_d       = deg_clamp;
          state_d     = polyr_pkg::ST_PREP;
        end
      end
      polyr_pkg::ST_PREP: begin
        ctrl_o.prep = 1'b1;
        state_d     = polyr_pkg::ST_MUL_LO;
      end
      polyr_pkg::ST_MUL_LO: begin
        ctrl_o.mul_lo = 1'b1;
        state_d       = polyr_pkg::ST_MUL_HI;
      end
      polyr_pkg::ST_MUL_HI: begin
        ctrl_o.mul_hi = 1'b1;
        state_d       = polyr_pkg::ST_ACCUM;
      end
      polyr_pkg::ST_ACCUM: begin
        ctrl_o.accum = 1'b1;
        if (idx_q == '0) begin
          state_d = polyr_pkg::ST_FMAG;
        end else begin
          idx_d   = idx_q - CIDX_W'(1);
          state_d = polyr_pkg::ST_PREP;
        end
      end
      polyr_pkg::ST_FMAG: begin
        ctrl_o.fmag = 1'b1;
        state_d     = polyr_pkg::ST_ROUND;
      end
      polyr_pkg::ST_ROUND: begin
        ctrl_o.round = 1'b1;
        done_d       = 1'b1;
        state_d      = polyr_pkg::ST_IDLE;
      end
      default: begin
        state_d = polyr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= polyr_pkg::ST_IDLE;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  assign busy       = (state_q != polyr_pkg::ST_IDLE);
  assign done_o     = done_q;
  assign coef_sel_o = idx_q;

endmodule

// ===== rtl/polyr_dp.sv =====
// Datapath: accumulator, product register, rescale/add and final rounding.
module polyr_dp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  polyr_pkg::dp_ctrl_t                  ctrl_i,
  input  logic signed [polyr_pkg::X_W-1:0]     sample_x_i,
  input  logic signed [polyr_pkg::COEF_W-1:0]  coef_i,
  output logic signed [polyr_pkg::OUT_W-1:0]   result_value_o,
  output logic                                 clipped_o
);

  localparam logic [polyr_pkg::PROD_W-1:0] PROD_HALF =
    polyr_pkg::PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [polyr_pkg::RND_W-1:0] RND_HALF =
    polyr_pkg::RND_W'(1) << (FRAC_BITS - 1);

  logic [polyr_pkg::X_W-1:0]    xmag_q;
  logic                         xneg_q;
  logic [polyr_pkg::ACC_W-1:0]  acc_q;
  logic [polyr_pkg::ACC_W-1:0]  amag_q;
  logic                         neg_q;
  logic [polyr_pkg::PROD_W-1:0] prod_q;
  logic                         clip_q, clip_d;
  logic [polyr_pkg::OUT_W-1:0]  res_q, res_d;
  logic                         clip_out_q, clip_out_d;

  logic [polyr_pkg::PP_W-1:0]   pp;
  logic [polyr_pkg::ACC_W-1:0]  limit;
  logic                         prod_over;
  logic [polyr_pkg::ACC_W-1:0]  rv;
  logic [polyr_pkg::SUM_W-1:0]  coef_ext, rv_ext, sum;
  logic                         sum_in_range;
  logic [polyr_pkg::ACC_W-1:0]  acc_new;
  logic [polyr_pkg::RND_W-1:0]  rnd;

  polyr_mul u_mul (
    .amag_i (amag_q),
    .xmag_i (xmag_q),
    .hi_i   (ctrl_i.mul_hi),
    .pp_o   (pp)
  );

  // rescale product, saturate, add coefficient, saturate
  assign limit     = neg_q ? polyr_pkg::ACC_MIN : polyr_pkg::ACC_MAX;
  assign prod_over = (prod_q >> FRAC_BITS) > polyr_pkg::PROD_W'(limit);
  assign rv        = prod_over ? limit : prod_q[FRAC_BITS +: polyr_pkg::ACC_W];
  assign coef_ext  = {{(polyr_pkg::SUM_W-polyr_pkg::COEF_W){coef_i[polyr_pkg::COEF_W-1]}},
                      coef_i};
  assign rv_ext    = {2'b00, rv};
  assign sum       = neg_q ? (coef_ext - rv_ext) : (coef_ext + rv_ext);
  assign sum_in_range = (&sum[polyr_pkg::SUM_W-1:polyr_pkg::ACC_W-1]) |
                        ~(|sum[polyr_pkg::SUM_W-1:polyr_pkg::ACC_W-1]);
  assign acc_new   = sum_in_range ? sum[polyr_pkg::ACC_W-1:0]
                   : (sum[polyr_pkg::SUM_W-1] ? polyr_pkg::ACC_MIN : polyr_pkg::ACC_MAX);

  // final round to integer and clamp to 16 bits
  assign rnd = (polyr_pkg::RND_W'(amag_q) + RND_HALF) >> FRAC_BITS;

  always_comb begin
    clip_d     = clip_q;
    res_d      = res_q;
    clip_out_d = clip_out_q;
    if (ctrl_i.load) begin
      clip_d = 1'b0;
    end
    if (ctrl_i.accum && (prod_over || !sum_in_range)) begin
      clip_d = 1'b1;
    end
    if (ctrl_i.round) begin
      clip_out_d = clip_q;
      if (!acc_q[polyr_pkg::ACC_W-1]) begin
        if (rnd > polyr_pkg::RND_W'(polyr_pkg::OUT_MAX)) begin
          res_d      = polyr_pkg::OUT_MAX;
          clip_out_d = 1'b1;
        end else begin
          res_d = rnd[polyr_pkg::OUT_W-1:0];
        end
      end else begin
        if (rnd > polyr_pkg::RND_W'(polyr_pkg::OUT_MIN)) begin
          res_d      = polyr_pkg::OUT_MIN;
          clip_out_d = 1'b1;
        end else begin
          res_d = -rnd[polyr_pkg::OUT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= 1'b0;
    end else begin
      clip_q <= clip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    clip_out_q <= clip_out_d;
    if (ctrl_i.load) begin
      xneg_q <= sample_x_i[polyr_pkg::X_W-1];
      xmag_q <= sample_x_i[polyr_pkg::X_W-1] ? -sample_x_i : sample_x_i;
      acc_q  <= '0;
    end
    if (ctrl_i.prep || ctrl_i.fmag) begin
      amag_q <= acc_q[polyr_pkg::ACC_W-1] ? -acc_q : acc_q;
      neg_q  <= acc_q[polyr_pkg::ACC_W-1] ^ xneg_q;
    end
    if (ctrl_i.mul_lo) begin
      prod_q <= polyr_pkg::PROD_W'(pp) + PROD_HALF;
    end
    if (ctrl_i.mul_hi) begin
      prod_q <= prod_q + (polyr_pkg::PROD_W'(pp) << polyr_pkg::MUL_A_W);
    end
    if (ctrl_i.accum) begin
      acc_q <= acc_new;
    end
  end

  assign result_value_o = $signed(res_q);
  assign clipped_o      = clip_out_q;

endmodule

// ===== test/polynomial_eval_round_saturate_tb.sv =====
// Testbench for the Horner polynomial evaluator: directed corners, then randomized coefficient sets.
module polynomial_eval_round_saturate_tb;

  localparam int unsigned MAX_DEG     = 6;
  localparam int unsigned FRAC        = 16;
  localparam int unsigned LATENCY     = 4 * (MAX_DEG + 1) + 3;
  localparam int unsigned DRAIN_LIMIT = 8 * LATENCY;
  localparam int unsigned PHASES      = 30;
  localparam int unsigned PHASE_ITEMS = 55;

  localparam logic [polyr_pkg::CFG_IDX_W-1:0] REG_COEF0 = polyr_pkg::REG_DEGREE + 3'd1;

  localparam longint ACC_TOP = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_BOT = -ACC_TOP - 1;
  localparam longint OUT_TOP = 32767;
  localparam longint OUT_BOT = -32768;

  localparam logic [31:0] W_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN  = 32'h8000_0000;
  localparam logic [31:0] W_ONE  = 32'h0001_0000;
  localparam logic [31:0] W_HALF = 32'h0000_8000;

  typedef enum int unsigned { SPAN_FULL, SPAN_UNIT, SPAN_MID, SPAN_EDGE } span_e;

  typedef struct packed {
    logic signed [polyr_pkg::OUT_W-1:0] value;
    logic                               clipped;
  } poly_word_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic signed [polyr_pkg::X_W-1:0]    sample_x_i = '0;
  logic                                done_o;
  logic signed [polyr_pkg::OUT_W-1:0]  result_value_o;
  logic                                clipped_o;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [polyr_pkg::CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [polyr_pkg::COEF_W-1:0]        cfg_data_i = '0;

  logic [polyr_pkg::DEG_W-1:0]         deg_reg = '0;
  logic signed [31:0]                  coef_reg [MAX_DEG+1];
  poly_word_t                          poly_expect_q [$];
  poly_word_t                          head_word;
  bit                                  burst = 1'b0;
  int unsigned                         n_fail = 0;
  int unsigned                         n_sent = 0;
  int unsigned                         n_seen = 0;
  int unsigned                         n_clipped = 0;
  int unsigned                         n_sets = 0;

  polynomial_eval_round_saturate #(
    .MAX_DEGREE(MAX_DEG),
    .FRAC_BITS (FRAC)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .sample_x_i    (sample_x_i),
    .done_o        (done_o),
    .result_value_o(result_value_o),
    .clipped_o     (clipped_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // acc*x back to FRAC fraction bits, magnitude rounded half away from zero, 48-bit limit
  function automatic longint rescale_product(input longint acc, input longint x,
                                             inout logic clip);
    logic [127:0] ma, mb, prod, lim;
    logic         neg;
    longint       r;
    neg  = (acc < 0) != (x < 0);
    ma   = (acc < 0) ? -acc : acc;
    mb   = (x < 0) ? -x : x;
    prod = (ma * mb + (128'd1 << (FRAC - 1))) >> FRAC;
    lim  = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    if (prod > lim) begin
      clip = 1'b1;
      prod = lim;
    end
    r = prod[63:0];
    return neg ? -r : r;
  endfunction

  function automatic poly_word_t horner_eval(input logic signed [31:0] sample);
    poly_word_t w;
    longint     x, acc, mag, r, v;
    logic       clip;
    int         top;
    x    = longint'(sample);
    acc  = 0;
    clip = 1'b0;
    top  = (deg_reg > MAX_DEG) ? MAX_DEG : int'(deg_reg);
    for (int i = top; i >= 0; i--) begin
      acc = rescale_product(acc, x, clip) + longint'(coef_reg[i]);
      if (acc > ACC_TOP) begin
        acc  = ACC_TOP;
        clip = 1'b1;
      end else if (acc < ACC_BOT) begin
        acc  = ACC_BOT;
        clip = 1'b1;
      end
    end
    mag = (acc < 0) ? -acc : acc;
    r   = (mag + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    v   = (acc < 0) ? -r : r;
    if (v > OUT_TOP) begin
      v    = OUT_TOP;
      clip = 1'b1;
    end else if (v < OUT_BOT) begin
      v    = OUT_BOT;
      clip = 1'b1;
    end
    w.value   = v[15:0];
    w.clipped = clip;
    return w;
  endfunction

  function automatic logic [31:0] draw_word(input span_e span);
    logic [31:0] w;
    case (span)
      SPAN_FULL: w = $urandom();
      SPAN_UNIT: w = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      SPAN_MID:  w = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: begin
        case ($urandom_range(0, 5))
          0: w = W_MAX;
          1: w = W_MIN;
          2: w = '0;
          3: w = 32'h0000_0001;
          4: w = '1;
          default: w = W_HALF;
        endcase
      end
    endcase
    return w;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_seen++;
      if (clipped_o) n_clipped++;
      if (poly_expect_q.size() == 0) begin
        $display("%0t: unexpected word, value %0d clipped %0b", $time, result_value_o,
                 clipped_o);
        n_fail++;
      end else begin
        head_word = poly_expect_q.pop_front();
        if (result_value_o !== head_word.value) begin
          $display("%0t: value mismatch, expected %0d actual %0d", $time, head_word.value,
                   result_value_o);
          n_fail++;
        end
        if (clipped_o !== head_word.clipped) begin
          $display("%0t: clipped mismatch, expected %0b actual %0b", $time,
                   head_word.clipped, clipped_o);
          n_fail++;
        end
      end
    end
  end

  task automatic write_reg(input logic [polyr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      cfg_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == polyr_pkg::REG_DEGREE) deg_reg = data[polyr_pkg::DEG_W-1:0];
    else coef_reg[idx - REG_COEF0] = data;
  endtask

  // degree word carries random upper bits, which the block must ignore
  task automatic load_poly(input logic [2:0] deg, input logic [MAX_DEG:0][31:0] coefs);
    logic [31:0] deg_word;
    deg_word = {$urandom_range(0, 1) ? 29'($urandom()) : 29'd0, deg};
    write_reg(polyr_pkg::REG_DEGREE, deg_word);
    for (int i = 0; i <= MAX_DEG; i++)
      write_reg(polyr_pkg::CFG_IDX_W'(REG_COEF0 + i), coefs[i]);
    cfg_valid_i <= 1'b0;
    n_sets++;
  endtask

  task automatic send_sample(input logic [31:0] x);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    sample_x_i <= x;
    do @(posedge clk_i); while (busy);
    poly_expect_q.push_back(horner_eval(x));
    n_sent++;
  endtask

  task automatic wait_results_done();
    int unsigned waited;
    if (start) start <= 1'b0;
    waited = 0;
    while ((poly_expect_q.size() != 0 || busy) && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (poly_expect_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, poly_expect_q.size());
      n_fail++;
      poly_expect_q.delete();
    end
  endtask

  task automatic test_reset_state();
    send_sample(W_MAX);
    send_sample(W_MIN);
    wait_results_done();
  endtask

  // constant polynomials: half-way rounding and the 16-bit output limits
  task automatic test_rounding_edges();
    logic [MAX_DEG:0][31:0] c;
    logic [4:0][31:0]       a0;
    a0 = {W_MAX, W_MIN, W_HALF, 32'hFFFF_8000, 32'h7FFF_7FFF};
    for (int i = 0; i < 5; i++) begin
      c    = '0;
      c[0] = a0[i];
      load_poly(3'd0, c);
      send_sample($urandom());
      wait_results_done();
    end
  endtask

  // y = x, then a one-LSB slope: sample extremes and half-way samples
  task automatic test_linear_extremes();
    logic [MAX_DEG:0][31:0] c;
    c    = '0;
    c[1] = W_ONE;
    load_poly(3'd1, c);
    send_sample(W_MAX);
    send_sample(W_MIN);
    send_sample(32'h0001_8000);
    send_sample(32'hFFFE_8000);
    c[1] = 32'h0000_0001;
    wait_results_done();
    load_poly(3'd1, c);
    send_sample(W_HALF);
    wait_results_done();
  endtask

  // full degree with largest terms: product and accumulator limits, degree 7 folds to 6
  task automatic test_full_degree();
    logic [MAX_DEG:0][31:0] c;
    for (int i = 0; i <= MAX_DEG; i++) c[i] = W_MAX;
    load_poly(3'd6, c);
    send_sample(W_MAX);
    send_sample(W_MIN);
    wait_results_done();
    load_poly(3'd7, c);
    send_sample(W_MAX);
    wait_results_done();
    for (int i = 0; i <= MAX_DEG; i++) c[i] = i[0] ? W_MIN : W_MAX;
    load_poly(3'd6, c);
    send_sample(32'hFFFF_0000);
    wait_results_done();
  endtask

  task automatic test_random_phases();
    logic [MAX_DEG:0][31:0] c;
    logic [2:0]             deg;
    span_e                  base, xs;
    int unsigned            pick;
    for (int p = 0; p < PHASES; p++) begin
      burst = ($urandom_range(0, 3) == 0);
      deg   = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
      base  = span_e'($urandom_range(0, 3));
      for (int i = 0; i <= MAX_DEG; i++)
        c[i] = draw_word(($urandom_range(0, 3) == 0) ? span_e'($urandom_range(0, 3)) : base);
      load_poly(deg, c);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 9);
        xs   = (pick < 6) ? SPAN_UNIT : (pick < 8) ? SPAN_MID : (pick == 8) ? SPAN_FULL
                                                                       : SPAN_EDGE;
        send_sample(draw_word(xs));
        if ($urandom_range(0, 39) == 0) wait_results_done();
      end
      wait_results_done();
    end
    burst = 1'b0;
  endtask

  initial begin
    for (int i = 0; i <= MAX_DEG; i++) coef_reg[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_rounding_edges();
    test_linear_extremes();
    test_full_degree();
    test_random_phases();
    wait_results_done();
    repeat (2 * LATENCY) @(posedge clk_i);
    $display("Evaluated %0d samples over %0d coefficient sets, degree words 0 to 7.", n_sent,
             n_sets);
    $display("Checked %0d result words, %0d of them clipped.", n_seen, n_clipped);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/polyr_pkg.sv
rtl/polyr_cfg.sv
rtl/polyr_mul.sv
rtl/polyr_ctrl.sv
rtl/polyr_dp.sv
rtl/polynomial_eval_round_saturate.sv
test/polynomial_eval_round_saturate_tb.sv
